### rtl/core/sliding_window_ratio_detector_unit_defines.svh
// Assertion helpers used by the detector datapath.
`ifndef SLIDING_WINDOW_RATIO_DETECTOR_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_RATIO_DETECTOR_UNIT_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define SWRD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent implies the consequent in the cycle after it.
`define SWRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/swrd_pkg.sv
package swrd_pkg;

  localparam int ADDRESS_BITS = 48;
  localparam int CNT_BITS     = 10;
  localparam int RATIO_BITS   = 17;
  localparam int MIN_BITS     = 8;
  localparam int LIMIT_BITS   = 10;
  localparam int CFG_BITS     = 17;
  localparam int CFG_IDX_BITS = 2;
  localparam int FRAC_BITS    = 16;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RATIO_Q16    = 2'd0;
  localparam cfg_idx_t CFG_MIN_INTERVAL = 2'd1;
  localparam cfg_idx_t CFG_WINDOW_LIMIT = 2'd2;

  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 17'd26214;
  localparam logic [MIN_BITS-1:0]   MIN_RESET   = 8'd15;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd100;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] block_address;
    logic [CNT_BITS-1:0]     block_size;
    logic [CNT_BITS-1:0]     logic_count;
  } in_word_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] golden_address;
    logic                    table_full;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic drop_rd;
    logic drop_sub;
    logic push;
    logic walk_init;
    logic walk_sum;
    logic walk_mul;
    logic scan_start;
    logic scan_sel_walk;
    logic emit;
    logic walk_next;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic drop_needed;
    logic ratio_ok;
    logic scan_busy;
    logic scan_hit;
    logic walk_pass;
    logic walk_end;
    logic out_free;
    logic pend_valid;
  } status_t;

endpackage

### rtl/core/swrd_ram.sv
module swrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/swrd_ctrl.sv
module swrd_ctrl import swrd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd,
  output logic    idle
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DCHK  = 15'b000000000000010,
    S_DRD   = 15'b000000000000100,
    S_DSUB  = 15'b000000000001000,
    S_PUSH  = 15'b000000000010000,
    S_RCHK  = 15'b000000000100000,
    S_NWAIT = 15'b000000001000000,
    S_WRD   = 15'b000000010000000,
    S_WSUM  = 15'b000000100000000,
    S_WMUL  = 15'b000001000000000,
    S_WTEST = 15'b000010000000000,
    S_WWAIT = 15'b000100000000000,
    S_EMIT  = 15'b001000000000000,
    S_WNEXT = 15'b010000000000000,
    S_FLUSH = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_DCHK;
        end
      end
      S_DCHK: state_next = status.drop_needed ? S_DRD : S_PUSH;
      S_DRD: begin
        cmd.drop_rd = 1'b1;
        state_next = S_DSUB;
      end
      S_DSUB: begin
        cmd.drop_sub = 1'b1;
        state_next = S_DCHK;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_next = S_RCHK;
      end
      S_RCHK: begin
        cmd.walk_init = 1'b1;
        if (status.ratio_ok) begin
          cmd.scan_start = 1'b1;
          state_next = S_NWAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_NWAIT: begin
        if (!status.scan_busy) begin
          state_next = status.scan_hit ? S_IDLE : S_WRD;
        end
      end
      S_WRD: state_next = S_WSUM;
      S_WSUM: begin
        cmd.walk_sum = 1'b1;
        state_next = S_WMUL;
      end
      S_WMUL: begin
        cmd.walk_mul = 1'b1;
        state_next = S_WTEST;
      end
      S_WTEST: begin
        if (status.walk_pass) begin
          cmd.scan_start = 1'b1;
          cmd.scan_sel_walk = 1'b1;
          state_next = S_WWAIT;
        end else begin
          state_next = S_WNEXT;
        end
      end
      S_WWAIT: begin
        if (!status.scan_busy) begin
          state_next = status.scan_hit ? S_WNEXT : S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_WNEXT;
        end
      end
      S_WNEXT: begin
        cmd.walk_next = 1'b1;
        state_next = status.walk_end ? S_FLUSH : S_WRD;
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign idle = (state == S_IDLE);

endmodule

### rtl/core/swrd_datapath.sv
`include "sliding_window_ratio_detector_unit_defines.svh"

module swrd_datapath import swrd_pkg::*; #(
  parameter int WINDOW_ENTRIES = 32,
  parameter int GOLDEN_ENTRIES = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  cfg_idx_t                cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  in_word_t                in_data,
  input  cmd_t                    cmd,
  output status_t                 status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_word_t               out_data
);

  localparam int HW = $clog2(WINDOW_ENTRIES);
  localparam int FW = $clog2(WINDOW_ENTRIES + 1);
  localparam int PW = HW + 2;
  localparam int TW = $clog2((WINDOW_ENTRIES + 1) * 1024);
  localparam int CW = TW + RATIO_BITS;
  localparam int GA = $clog2(GOLDEN_ENTRIES);
  localparam int GF = $clog2(GOLDEN_ENTRIES + 1);
  localparam int WW = ADDRESS_BITS + 2 * CNT_BITS;
  localparam logic [PW-1:0] NP = PW'(WINDOW_ENTRIES);
  localparam logic [FW-1:0] NF = FW'(WINDOW_ENTRIES);
  localparam logic [GF-1:0] GFULL = GF'(GOLDEN_ENTRIES);

  logic [RATIO_BITS-1:0] ratio_q16;
  logic [MIN_BITS-1:0]   min_interval;
  logic [LIMIT_BITS-1:0] window_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_q16    <= RATIO_RESET;
      min_interval <= MIN_RESET;
      window_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RATIO_Q16:    ratio_q16    <= cfg_data[RATIO_BITS-1:0];
        CFG_MIN_INTERVAL: min_interval <= cfg_data[MIN_BITS-1:0];
        CFG_WINDOW_LIMIT: window_limit <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window store: a ring with the newest word at head.
  in_word_t        cur;
  logic [HW-1:0]   head;
  logic [FW-1:0]   fill;
  logic [TW-1:0]   instr_total;
  logic [TW-1:0]   logic_total;
  logic [HW-1:0]   walk_k;
  logic [HW-1:0]   head_inc;
  logic [PW-1:0]   old_tmp;
  logic [HW-1:0]   oldest_idx;
  logic [HW-1:0]   walk_idx;
  logic [HW-1:0]   win_raddr;
  logic [WW-1:0]   win_rdata;
  logic [ADDRESS_BITS-1:0] win_addr;
  logic [CNT_BITS-1:0]     win_size;
  logic [CNT_BITS-1:0]     win_logic;

  assign head_inc = (head == HW'(WINDOW_ENTRIES - 1)) ? '0 : head + 1'b1;
  assign old_tmp = {2'b00, head} + NP - PW'(fill) + PW'(1);
  assign oldest_idx = (old_tmp >= NP) ? HW'(old_tmp - NP) : old_tmp[HW-1:0];
  assign walk_idx = (head >= walk_k) ? head - walk_k : HW'(PW'(head) + NP - PW'(walk_k));
  assign win_raddr = cmd.drop_rd ? oldest_idx : walk_idx;
  assign {win_addr, win_size, win_logic} = win_rdata;

  swrd_ram #(.WIDTH(WW), .DEPTH(WINDOW_ENTRIES)) u_window (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (head_inc),
    .wdata ({cur.block_address, cur.block_size, cur.logic_count}),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      fill        <= '0;
      instr_total <= '0;
      logic_total <= '0;
    end else if (cmd.load_in) begin
      instr_total <= instr_total + TW'(in_data.block_size);
      logic_total <= logic_total + TW'(in_data.logic_count);
    end else if (cmd.drop_sub) begin
      fill        <= fill - 1'b1;
      instr_total <= instr_total - TW'(win_size);
      logic_total <= logic_total - TW'(win_logic);
    end else if (cmd.push) begin
      head <= head_inc;
      fill <= fill + 1'b1;
    end
  end

  assign status.drop_needed = ((instr_total >= TW'(window_limit)) && (fill != '0))
                              || (fill == NF);

  logic [CW-1:0] new_lhs;
  logic [CW-1:0] new_rhs;
  assign new_lhs = CW'({logic_total, {FRAC_BITS{1'b0}}});
  assign new_rhs = CW'(ratio_q16) * CW'(min_interval);
  assign status.ratio_ok = (new_lhs >= new_rhs);

  // Walk over the window from newest to oldest.
  logic [TW-1:0]           sum_size;
  logic [TW-1:0]           sum_logic;
  logic [ADDRESS_BITS-1:0] walk_addr;
  logic [CW-1:0]           prod;

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_k    <= '0;
      sum_size  <= '0;
      sum_logic <= '0;
    end else if (cmd.walk_sum) begin
      sum_size  <= sum_size + TW'(win_size);
      sum_logic <= sum_logic + TW'(win_logic);
      walk_addr <= win_addr;
    end else if (cmd.walk_next) begin
      walk_k <= walk_k + 1'b1;
    end
    if (cmd.walk_mul) begin
      prod <= CW'(ratio_q16) * CW'(sum_size);
    end
  end

  assign status.walk_pass = (sum_size >= TW'(min_interval))
                            && (CW'({sum_logic, {FRAC_BITS{1'b0}}}) >= prod);
  assign status.walk_end = (FW'(walk_k) + 1'b1 == fill);

  // Golden table search: one entry read per cycle over the filled part.
  logic [GF-1:0]           golden_fill;
  logic [GF-1:0]           scan_k;
  logic                    scan_busy;
  logic                    scan_pv;
  logic                    scan_hit;
  logic [ADDRESS_BITS-1:0] scan_key;
  logic [ADDRESS_BITS-1:0] g_rdata;
  logic                    g_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      scan_pv   <= 1'b0;
      scan_hit  <= 1'b0;
      scan_k    <= '0;
    end else if (cmd.scan_start) begin
      scan_busy <= 1'b1;
      scan_pv   <= 1'b0;
      scan_hit  <= 1'b0;
      scan_k    <= '0;
    end else if (scan_busy) begin
      if (scan_pv && (g_rdata == scan_key)) begin
        scan_hit <= 1'b1;
      end
      if (scan_k < golden_fill) begin
        scan_k  <= scan_k + 1'b1;
        scan_pv <= 1'b1;
      end else begin
        scan_pv <= 1'b0;
        if (!scan_pv) begin
          scan_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_key <= cmd.scan_sel_walk ? walk_addr : cur.block_address;
    end
  end

  assign status.scan_busy = scan_busy;
  assign status.scan_hit  = scan_hit;
  assign g_we = cmd.emit && (golden_fill != GFULL);

  swrd_ram #(.WIDTH(ADDRESS_BITS), .DEPTH(GOLDEN_ENTRIES)) u_golden (
    .clk   (clk),
    .we    (g_we),
    .waddr (golden_fill[GA-1:0]),
    .wdata (walk_addr),
    .raddr (scan_k[GA-1:0]),
    .rdata (g_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      golden_fill <= '0;
    end else if (g_we) begin
      golden_fill <= golden_fill + 1'b1;
    end
  end

  // The newest result is held back until it is known whether it is the last one.
  logic                    pend_valid;
  logic [ADDRESS_BITS-1:0] pend_addr;
  logic                    pend_full;
  logic                    out_taken;
  logic                    out_load;

  assign out_taken = out_valid && !out_stall;
  assign out_load = (cmd.emit && pend_valid) || cmd.flush;
  assign status.out_free = !out_valid || !out_stall;
  assign status.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_addr <= walk_addr;
      pend_full <= (golden_fill == GFULL);
    end
    if (out_load) begin
      out_data.golden_address <= pend_addr;
      out_data.table_full     <= pend_full;
      out_data.last           <= cmd.flush;
    end
  end

  `SWRD_ASSERT(a_fill_bound, fill <= NF, "window fill above capacity")
  `SWRD_ASSERT(a_golden_bound, golden_fill <= GFULL, "golden fill above capacity")
  `SWRD_ASSERT(a_no_overwrite, !out_load || !out_valid || out_taken,
               "output word overwritten before it was taken")
  `SWRD_ASSERT_NEXT(a_scan_starts, cmd.scan_start, scan_busy && !scan_hit,
                    "golden search did not start cleanly")

endmodule

### rtl/core/sliding_window_ratio_detector_unit.sv
// Per word: drop the oldest window entries while the limit or capacity is reached,
// push the word and test the ratio; on a pass, search the golden table for its address,
// and on a miss walk the window, emitting each passing entry not yet in the golden table.
// A new input word is taken only once the last is done; output stalls can hold the walk.
// Reset (rst, synchronous, active high) restores the register defaults, empties the
// window and the golden table and drops any pending result; no clearing pass is needed.
module sliding_window_ratio_detector_unit import swrd_pkg::*; #(
  parameter int WINDOW_ENTRIES = 32,
  parameter int GOLDEN_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  cfg_idx_t            cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_data
);

  cmd_t    cmd;
  status_t status;
  logic    idle;

  swrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle)
  );

  swrd_datapath #(
    .WINDOW_ENTRIES (WINDOW_ENTRIES),
    .GOLDEN_ENTRIES (GOLDEN_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !idle;

endmodule
